// ----- rtl/core/thbt_pkg.sv -----
`timescale 1ns / 1ps
package thbt_pkg;

    localparam int CELSIUS_W = 13;
    localparam int LOG_W     = 30;   // log2 in Q24, integer part up to 6 bits
    localparam int MANT_W    = 32;   // normalized mantissa, Q30
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 64;
    localparam int DEN_W     = 48;
    localparam int NUM_W     = 62;
    localparam int DIV_W     = 68;
    localparam int Q_W       = 20;

    localparam logic [CELSIUS_W-1:0] CELSIUS_MAX = 13'd4095;
    localparam logic [CELSIUS_W-1:0] CELSIUS_MIN = 13'h1EEF;   // -273
    localparam logic [Q_W-1:0]       CK_LIMIT    = 20'd436915; // (4095+1)*100 + 27315
    localparam logic [Q_W:0]         ZERO_C_CK   = 21'd27315;
    localparam logic [MUL_W-1:0]     LN2_Q30     = 32'd744261118;
    localparam logic [MUL_W-1:0]     RECIP_100   = 32'd671089;  // ceil(2^26 / 100)

    localparam logic [1:0] CFG_SERIES  = 2'd0;
    localparam logic [1:0] CFG_NOMINAL = 2'd1;
    localparam logic [1:0] CFG_NOM_C   = 2'd2;
    localparam logic [1:0] CFG_BETA    = 2'd3;

endpackage

// ----- rtl/core/thermistor_beta_temperature.sv -----
`timescale 1ns / 1ps
// Each sample runs two log2 evaluations, each a leading-one search and then 24 squarings
//   through the one shared 32x32 multiplier, and then a 20-step divide.
//   Zero, full-scale or zero-register cases go straight to the result.
//   An output stall holds the finished result in S_FIN until the output register is free.
// s_tready is high only while idle, so a new sample is taken only after the last result is written out.
// Reset (aresetn, synchronous): window and sum cleared, registers to 4100 / 100000 / 25 / 3950.
module thermistor_beta_temperature #(
    parameter int WINDOW_LEN = 10,
    parameter int ADC_BITS   = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [9:0] adc_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [12:0] celsius, [13] out_of_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int FULL_SCALE = WINDOW_LEN * ((1 << ADC_BITS) - 1);
    localparam int SUM_W      = $clog2(FULL_SCALE + 1);
    localparam int X_W        = 24 + SUM_W;
    localparam int CNT_W      = $clog2(X_W);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_NORM   = 5'd3;
    localparam logic [4:0] S_SQ_MUL = 5'd4;
    localparam logic [4:0] S_SQ_USE = 5'd5;
    localparam logic [4:0] S_MULB   = 5'd6;
    localparam logic [4:0] S_LN     = 5'd7;
    localparam logic [4:0] S_V      = 5'd8;
    localparam logic [4:0] S_P2     = 5'd9;
    localparam logic [4:0] S_DEN    = 5'd10;
    localparam logic [4:0] S_NUM1   = 5'd11;
    localparam logic [4:0] S_NUM2   = 5'd12;
    localparam logic [4:0] S_DIV    = 5'd13;
    localparam logic [4:0] S_C1     = 5'd14;
    localparam logic [4:0] S_C2     = 5'd15;
    localparam logic [4:0] S_FIN    = 5'd16;

    logic [4:0]  state_reg, state_next;

    logic [19:0] series_reg;
    logic [23:0] nominal_reg;
    logic [8:0]  nom_c_reg;
    logic [13:0] beta_reg;

    logic [SUM_W-1:0] sum;
    logic             accept;

    logic [thbt_pkg::PROD_W-1:0] prod_reg;
    logic [thbt_pkg::PROD_W-1:0] prod_next;
    logic [thbt_pkg::MUL_W-1:0]  mul_x, mul_y;

    logic [X_W-1:0]               x_reg, x_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [thbt_pkg::MANT_W-1:0]  m_reg, m_next;
    logic [thbt_pkg::LOG_W-1:0]   r_reg, r_next;
    logic [thbt_pkg::LOG_W-1:0]   la_reg, la_next;
    logic                         log_b_reg, log_b_next;
    logic [4:0]                   step_reg, step_next;
    logic                         neg_reg, neg_next;
    logic [46:0]                  p2_reg, p2_next;
    logic signed [thbt_pkg::DEN_W-1:0] den_reg, den_next;
    logic [thbt_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [thbt_pkg::DIV_W-1:0]   dsh_reg, dsh_next;
    logic [thbt_pkg::Q_W-1:0]     q_reg, q_next;
    logic [thbt_pkg::CELSIUS_W-1:0] res_c_reg, res_c_next;
    logic                         res_f_reg, res_f_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [thbt_pkg::CELSIUS_W-1:0] out_c_reg, out_c_next;
    logic                         out_f_reg, out_f_next;

    logic [16:0] t0c_w;
    logic [15:0] t0c;
    logic [33:0] sq_t;
    logic signed [thbt_pkg::LOG_W:0] l_diff;
    logic [thbt_pkg::LOG_W-1:0]  l_mag;
    logic [thbt_pkg::DEN_W-1:0]  beta_sh;
    logic [thbt_pkg::DIV_W-1:0]  num_w;
    logic [thbt_pkg::DIV_W-1:0]  den_w;
    logic [thbt_pkg::Q_W:0]      cc;
    logic [thbt_pkg::Q_W:0]      cc_mag;
    logic [12:0]                 qd;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, out_f_reg, out_c_reg};

    thbt_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .ADC_BITS   (ADC_BITS),
        .SUM_W      (SUM_W)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept),
        .sample   (ADC_BITS'(s_tdata[9:0])),
        .sum      (sum)
    );

    // nominal temperature in centikelvin, always positive for any 9-bit code
    assign t0c_w = {{8{nom_c_reg[8]}}, nom_c_reg} * 17'd100 + 17'd27315;
    assign t0c   = t0c_w[15:0];

    assign sq_t    = prod_reg[63:30];
    assign l_diff  = $signed({1'b0, la_reg}) - $signed({1'b0, r_reg});
    assign l_mag   = l_diff[thbt_pkg::LOG_W] ? 30'(-l_diff) : 30'(l_diff);
    assign beta_sh = thbt_pkg::DEN_W'(prod_reg[20:0]) << 24;
    assign num_w   = thbt_pkg::DIV_W'(prod_reg[37:0]) << 24;
    assign den_w   = thbt_pkg::DIV_W'(den_reg);
    assign cc      = {1'b0, q_reg} - thbt_pkg::ZERO_C_CK;
    assign cc_mag  = cc[thbt_pkg::Q_W] ? -cc : cc;
    assign qd      = prod_reg[38:26];

    // shared multiplier operand select
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (state_reg)
            S_CHECK: begin
                mul_x = 32'(series_reg);
                mul_y = 32'(sum);
            end
            S_MULB: begin
                mul_x = 32'(nominal_reg);
                mul_y = 32'(SUM_W'(FULL_SCALE) - sum);
            end
            S_SQ_MUL: begin
                mul_x = m_reg;
                mul_y = m_reg;
            end
            S_LN: begin
                mul_x = 32'(l_mag);
                mul_y = thbt_pkg::LN2_Q30;
            end
            S_V: begin
                mul_x = 32'(t0c);
                mul_y = 32'(prod_reg[61:30]);
            end
            S_P2: begin
                mul_x = 32'(beta_reg);
                mul_y = 32'd100;
            end
            S_DEN: begin
                mul_x = 32'(beta_reg);
                mul_y = 32'(t0c);
            end
            S_NUM1: begin
                mul_x = prod_reg[31:0];
                mul_y = 32'd100;
            end
            S_C1: begin
                mul_x = 32'(cc_mag);
                mul_y = thbt_pkg::RECIP_100;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign prod_next = mul_x * mul_y;

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        cnt_next      = cnt_reg;
        m_next        = m_reg;
        r_next        = r_reg;
        la_next       = la_reg;
        log_b_next    = log_b_reg;
        step_next     = step_reg;
        neg_next      = neg_reg;
        p2_next       = p2_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        res_c_next    = res_c_reg;
        res_f_next    = res_f_reg;
        m_tvalid_next = m_tvalid_reg;
        out_c_next    = out_c_reg;
        out_f_next    = out_f_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                log_b_next = 1'b0;
                if (sum == '0 || sum >= SUM_W'(FULL_SCALE) || series_reg == '0 ||
                    nominal_reg == '0 || beta_reg == '0) begin
                    res_c_next = thbt_pkg::CELSIUS_MIN;
                    res_f_next = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_LOAD;
                end
            end
            S_MULB: begin
                log_b_next = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                x_next     = prod_reg[X_W-1:0];
                cnt_next   = '0;
                state_next = S_NORM;
            end
            S_NORM: begin
                priority if (x_reg[X_W-1]) begin
                    m_next     = 32'(x_reg[X_W-1 -: 31]);
                    r_next     = (30'(X_W - 1) - 30'(cnt_reg)) << 24;
                    step_next  = 5'd23;
                    state_next = S_SQ_MUL;
                end else if (x_reg[X_W-1 -: 8] == '0) begin
                    x_next   = x_reg << 8;
                    cnt_next = cnt_reg + CNT_W'(8);
                end else begin
                    x_next   = x_reg << 1;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SQ_MUL: begin
                state_next = S_SQ_USE;
            end
            S_SQ_USE: begin
                if (sq_t[31]) begin
                    m_next           = 32'(sq_t[31:1]);
                    r_next[step_reg] = 1'b1;
                end else begin
                    m_next = sq_t[31:0];
                end
                if (step_reg == '0) begin
                    if (log_b_reg) begin
                        state_next = S_LN;
                    end else begin
                        la_next    = (sq_t[31]) ? (r_reg | 30'd1) : r_reg;
                        state_next = S_MULB;
                    end
                end else begin
                    step_next  = step_reg - 5'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_LN: begin
                neg_next   = l_diff[thbt_pkg::LOG_W];
                state_next = S_V;
            end
            S_V: begin
                state_next = S_P2;
            end
            S_P2: begin
                p2_next    = prod_reg[46:0];
                state_next = S_DEN;
            end
            S_DEN: begin
                den_next   = neg_reg ? $signed(beta_sh - 48'(p2_reg))
                                     : $signed(beta_sh + 48'(p2_reg));
                state_next = S_NUM1;
            end
            S_NUM1: begin
                state_next = S_NUM2;
            end
            S_NUM2: begin
                priority if (den_reg == '0) begin
                    res_c_next = thbt_pkg::CELSIUS_MAX;
                    res_f_next = 1'b1;
                    state_next = S_FIN;
                end else if (den_reg < 0) begin
                    res_c_next = thbt_pkg::CELSIUS_MIN;
                    res_f_next = 1'b1;
                    state_next = S_FIN;
                end else if (num_w >= (den_w << 20)) begin
                    res_c_next = thbt_pkg::CELSIUS_MAX;
                    res_f_next = 1'b1;
                    state_next = S_FIN;
                end else begin
                    rem_next   = num_w;
                    dsh_next   = den_w << 19;
                    q_next     = '0;
                    step_next  = 5'd19;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_reg >= dsh_reg) begin
                    rem_next = rem_reg - dsh_reg;
                    q_next   = {q_reg[thbt_pkg::Q_W-2:0], 1'b1};
                end else begin
                    q_next   = {q_reg[thbt_pkg::Q_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0) begin
                    state_next = S_C1;
                end else begin
                    step_next = step_reg - 5'd1;
                end
            end
            S_C1: begin
                neg_next = cc[thbt_pkg::Q_W];
                if (q_reg > thbt_pkg::CK_LIMIT) begin
                    res_c_next = thbt_pkg::CELSIUS_MAX;
                    res_f_next = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_C2;
                end
            end
            S_C2: begin
                if (!neg_reg && qd > thbt_pkg::CELSIUS_MAX) begin
                    res_c_next = thbt_pkg::CELSIUS_MAX;
                    res_f_next = 1'b1;
                end else begin
                    res_c_next = neg_reg ? -qd : qd;
                    res_f_next = 1'b0;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    out_c_next    = res_c_reg;
                    out_f_next    = res_f_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            log_b_reg    <= 1'b0;
            series_reg   <= 20'd4100;
            nominal_reg  <= 24'd100000;
            nom_c_reg    <= 9'd25;
            beta_reg     <= 14'd3950;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            log_b_reg    <= log_b_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    thbt_pkg::CFG_SERIES:  series_reg  <= cfg_data[19:0];
                    thbt_pkg::CFG_NOMINAL: nominal_reg <= cfg_data[23:0];
                    thbt_pkg::CFG_NOM_C:   nom_c_reg   <= cfg_data[8:0];
                    thbt_pkg::CFG_BETA:    beta_reg    <= cfg_data[13:0];
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        cnt_reg   <= cnt_next;
        m_reg     <= m_next;
        r_reg     <= r_next;
        la_reg    <= la_next;
        step_reg  <= step_next;
        neg_reg   <= neg_next;
        p2_reg    <= p2_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        q_reg     <= q_next;
        res_c_reg <= res_c_next;
        res_f_reg <= res_f_next;
        out_c_reg <= out_c_next;
        out_f_reg <= out_f_next;
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_CHECK)
        else $error("accepted sample did not start the sequencer");

    a_div_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg > 0)
        else $error("division started with a non-positive denominator");

    a_square_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SQ_USE |-> prod_reg[63:62] == 2'b00)
        else $error("mantissa square exceeded its range");

    a_flag_clear_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[13] |-> $signed(m_tdata[12:0]) >= -13'sd273)
        else $error("unflagged result below absolute zero");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && m_tvalid_reg && !m_tready |=> state_reg == S_FIN)
        else $error("result left the sequencer while output stalled");

endmodule

// ----- rtl/core/thbt_window.sv -----
`timescale 1ns / 1ps
module thbt_window #(
    parameter int WINDOW_LEN = 10,
    parameter int ADC_BITS   = 10,
    parameter int SUM_W      = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [ADC_BITS-1:0] sample,
    output logic [SUM_W-1:0]    sum
);

    logic [ADC_BITS-1:0] tap_reg [WINDOW_LEN];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;

    assign sum_next = sum_reg - SUM_W'(tap_reg[WINDOW_LEN-1]) + SUM_W'(sample);
    assign sum      = sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (shift_en) begin
            sum_reg    <= sum_next;
            tap_reg[0] <= sample;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

endmodule
